// ===== src/bcfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bcfa_pkg
// Shared types, command codes and BCD helpers for the clock field adjuster.
// ----------------------------------------------------------------------------
package bcfa_pkg;

	localparam int NumRegs = 7;

	// command codes
	localparam logic [2:0] CMD_WRITE  = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_INC    = 3'd2;
	localparam logic [2:0] CMD_DEC    = 3'd3;
	localparam logic [2:0] CMD_AMPM   = 3'd4;
	localparam logic [2:0] CMD_MODE   = 3'd5;

	// register indexes
	localparam logic [2:0] IDX_SEC     = 3'd0;
	localparam logic [2:0] IDX_MIN     = 3'd1;
	localparam logic [2:0] IDX_HOUR    = 3'd2;
	localparam logic [2:0] IDX_WEEKDAY = 3'd3;
	localparam logic [2:0] IDX_DATE    = 3'd4;
	localparam logic [2:0] IDX_MONTH   = 3'd5;
	localparam logic [2:0] IDX_YEAR    = 3'd6;

	// hours format codes
	localparam logic [1:0] FMT_24H = 2'd0;
	localparam logic [1:0] FMT_AM  = 2'd1;
	localparam logic [1:0] FMT_PM  = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] field_index;
		logic [7:0] write_data;
	} req_item_t;

	typedef struct packed {
		logic [7:0] field_value;
		logic [1:0] hour_format;
		logic       bad_index;
	} rsp_item_t;

	typedef logic [NumRegs-1:0][7:0] regs_t;

	// register write request from the datapath
	typedef struct packed {
		logic       en;
		logic [2:0] idx;
		logic [7:0] data;
	} reg_wr_t;

	// two BCD digits to binary, 0..165
	function automatic logic [7:0] bcd2bin(logic [7:0] b);
		return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
	endfunction

	// binary 0..99 to two BCD digits; tens by reciprocal multiply
	function automatic logic [7:0] bin2bcd(logic [6:0] v);
		logic [16:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 17'(v) * 17'd103;
		tens = prod[13:10];
		ones = v - {tens, 3'b000} - {2'b00, tens, 1'b0};
		return {tens, ones[3:0]};
	endfunction

	// wrap step within lo..hi; out of range snaps to lo (up) or hi (down)
	function automatic logic [6:0] step_val(logic [7:0] v, logic [7:0] lo,
	                                        logic [7:0] hi, logic up);
		logic [7:0] r;
		if (up) begin
			r = (v >= hi || v < lo) ? lo : v + 8'd1;
		end else begin
			r = (v <= lo || v > hi) ? hi : v - 8'd1;
		end
		return r[6:0];
	endfunction

endpackage

// ===== src/bcfa_exec.sv =====
// ----------------------------------------------------------------------------
// bcfa_exec
// Single-pass datapath: decodes one command against the current register
// set and produces the register write and the response item.
// ----------------------------------------------------------------------------
module bcfa_exec (
	input  bcfa_pkg::req_item_t req,
	input  bcfa_pkg::regs_t     regs,
	output bcfa_pkg::reg_wr_t   wr,
	output bcfa_pkg::rsp_item_t rsp
);
	import bcfa_pkg::*;

	logic       idx_ok;
	logic       up;
	logic [7:0] cur;
	logic [7:0] hr;
	logic [7:0] stepped;
	logic [7:0] hr_ampm;
	logic [7:0] hr_mode;
	logic [7:0] hr_new;
	logic [7:0] v24;
	logic [7:0] v12;

	assign idx_ok = (req.field_index != 3'd7);
	assign up     = (req.cmd == CMD_INC);
	assign cur    = idx_ok ? regs[req.field_index] : 8'h00;
	assign hr     = regs[IDX_HOUR];

	// step the addressed register up or down with its wrap limits
	always_comb begin
		case (req.field_index)
			IDX_SEC, IDX_MIN:
				stepped = bin2bcd(step_val(bcd2bin(cur), 8'd0, 8'd59, up));
			IDX_WEEKDAY:
				stepped = bin2bcd(step_val(bcd2bin(cur), 8'd1, 8'd7, up));
			IDX_DATE:
				stepped = bin2bcd(step_val(bcd2bin(cur), 8'd1, 8'd31, up));
			IDX_MONTH:
				stepped = bin2bcd(step_val(bcd2bin(cur & 8'h7F), 8'd1, 8'd12, up));
			IDX_YEAR:
				stepped = bin2bcd(step_val(bcd2bin(cur), 8'd0, 8'd99, up));
			IDX_HOUR: begin
				if (!cur[6]) begin
					stepped = bin2bcd(step_val(bcd2bin(cur), 8'd0, 8'd23, up));
				end else begin
					stepped = bin2bcd(step_val(bcd2bin(cur & 8'h1F), 8'd1, 8'd12, up))
					          | {2'b01, cur[5], 5'b00000};
				end
			end
			default:
				stepped = cur;
		endcase
	end

	// AM/PM flip, only in 12-hour mode
	always_comb begin
		if (hr[6:5] == 2'b11) begin
			hr_ampm = hr & 8'hDF;
		end else if (hr[6]) begin
			hr_ampm = hr | 8'h60;
		end else begin
			hr_ampm = hr;
		end
	end

	// 12/24 hour conversion
	always_comb begin
		v24 = 8'd0;
		v12 = 8'd0;
		if (!hr[6]) begin
			v24 = bcd2bin(hr);
			if (v24 > 8'd23) begin
				v24 = 8'd0;
			end
			if (v24 == 8'd0) begin
				hr_mode = bin2bcd(7'd12) | 8'h40;
			end else if (v24 == 8'd12) begin
				hr_mode = bin2bcd(7'd12) | 8'h60;
			end else if (v24 > 8'd12) begin
				hr_mode = bin2bcd(7'(v24 - 8'd12)) | 8'h60;
			end else begin
				hr_mode = bin2bcd(v24[6:0]) | 8'h40;
			end
		end else begin
			v12 = bcd2bin(hr & 8'h1F);
			if (v12 < 8'd1 || v12 > 8'd12) begin
				v12 = 8'd12;
			end
			if (!hr[5]) begin
				v12 = (v12 == 8'd12) ? 8'd0 : v12;
			end else begin
				v12 = (v12 == 8'd12) ? 8'd12 : v12 + 8'd12;
			end
			hr_mode = bin2bcd(v12[6:0]);
		end
	end

	// command decode: register write and response value
	always_comb begin
		wr         = '0;
		rsp        = '0;
		case (req.cmd)
			CMD_AMPM: begin
				wr.en            = 1'b1;
				wr.idx           = IDX_HOUR;
				wr.data          = hr_ampm;
				rsp.field_value  = hr_ampm;
			end
			CMD_MODE: begin
				wr.en            = 1'b1;
				wr.idx           = IDX_HOUR;
				wr.data          = hr_mode;
				rsp.field_value  = hr_mode;
			end
			CMD_WRITE: begin
				wr.en            = idx_ok;
				wr.idx           = req.field_index;
				wr.data          = req.write_data;
				rsp.field_value  = idx_ok ? req.write_data : 8'h00;
				rsp.bad_index    = !idx_ok;
			end
			CMD_INC, CMD_DEC: begin
				wr.en            = idx_ok;
				wr.idx           = req.field_index;
				wr.data          = stepped;
				rsp.field_value  = idx_ok ? stepped : 8'h00;
				rsp.bad_index    = !idx_ok;
			end
			default: begin
				// read and the unused codes
				rsp.field_value  = cur;
				rsp.bad_index    = !idx_ok;
			end
		endcase

		// hours format from the hours register after the command
		hr_new          = (wr.en && wr.idx == IDX_HOUR) ? wr.data : hr;
		rsp.hour_format = !hr_new[6] ? FMT_24H : (hr_new[5] ? FMT_PM : FMT_AM);
	end

endmodule

// ===== src/bcd_clock_field_adjuster_top.sv =====
// ----------------------------------------------------------------------------
// bcd_clock_field_adjuster_top
// Seven BCD time/calendar registers with write, read, step and hours-format
// commands, one response item per request item.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  req     | in        | req_item_t  | req_valid / req_stall
//  rsp     | out       | rsp_item_t  | rsp_valid / rsp_stall
//
//  One item per cycle while the response side is not stalled; an item goes
//  through the request register, then the response register, with the
//  read-modify-write of one clock register in between. Reset clears all seven
//  registers and both valid flags. A stalled response holds the request
//  register; req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module bcd_clock_field_adjuster_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bcfa_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bcfa_pkg::rsp_item_t rsp
);
	import bcfa_pkg::*;

	req_item_t req_s1;
	logic      valid_s1;
	regs_t     regs_q;
	rsp_item_t rsp_q;
	logic      rsp_valid_q;
	reg_wr_t   wr;
	rsp_item_t rsp_next;
	logic      out_free;
	logic      fire;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bcfa_exec u_exec (
		.req  (req_s1),
		.regs (regs_q),
		.wr   (wr),
		.rsp  (rsp_next)
	);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// clock registers, updated as the item moves to the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (fire && wr.en && wr.idx != 3'd7) begin
			regs_q[wr.idx] <= wr.data;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

endmodule

// ===== src/bcfa_checker.sv =====
// ----------------------------------------------------------------------------
// bcfa_checker
// Port-level checks for the clock field adjuster, bound to the top level.
// ----------------------------------------------------------------------------
module bcfa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input bcfa_pkg::req_item_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input bcfa_pkg::rsp_item_t rsp
);
	import bcfa_pkg::*;

	// a held request item keeps its payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request item changed while stalled");

	// a held response item keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response item changed while stalled");

	// requests back up only when a response is waiting and stalled
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled with response side free");

	// a bad index reports a zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_index |-> rsp.field_value == 8'h00)
		else $error("bad index with nonzero value");

	// the hours format never takes the unused code
	a_fmt_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.hour_format != 2'd3)
		else $error("hours format out of range");

endmodule

bind bcd_clock_field_adjuster_top bcfa_checker u_bcfa_checker (.*);

// ===== sim/bcd_clock_field_adjuster_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_clock_field_adjuster_top_tb
// Self-checking bench for the BCD clock field adjuster. A short table of
// directed commands covers the wrap points, the hours-mode conversions and
// the index error, then random commands run through a clean phase and phases
// with sender gaps, receiver stalls, both, and one long receiver hold-off that
// backs the block up. Every response is checked field by field against a typed
// expectation or a behavioral copy of the clock registers.
// ----------------------------------------------------------------------------
module bcd_clock_field_adjuster_top_tb;
	import bcfa_pkg::*;

	// codes the package leaves unnamed
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [2:0] IDX_NONE   = 3'd7;

	// hours and month register bits
	localparam logic [7:0] HR_12H  = 8'h40;
	localparam logic [7:0] HR_PM   = 8'h20;
	localparam logic [7:0] HR_LOW5 = 8'h1F;
	localparam logic [7:0] MON_LOW = 8'h7F;
	localparam logic [7:0] CENTURY = 8'h80;

	localparam int ITEMS_PER_PHASE = 285;
	localparam int NUM_PHASES      = 5;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam int TIMEOUT_NS      = 400000;

	typedef struct packed {
		req_item_t stim;
		logic      has_want;
		rsp_item_t want;
	} dir_row_t;

	localparam rsp_item_t NO_RSP = '0;
	localparam int NUM_DIRECTED = 27;

	// typed expectations only where obvious; other rows use the predictor
	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		'{'{CMD_READ,   IDX_SEC,     8'h00}, 1'b1, '{8'h00, FMT_24H, 1'b0}},
		'{'{CMD_READ,   IDX_NONE,    8'h00}, 1'b1, '{8'h00, FMT_24H, 1'b1}},
		'{'{CMD_WRITE,  IDX_NONE,    8'hFF}, 1'b1, '{8'h00, FMT_24H, 1'b1}},
		'{'{CMD_SPARE7, IDX_NONE,    8'h00}, 1'b1, '{8'h00, FMT_24H, 1'b1}},
		'{'{CMD_WRITE,  IDX_SEC,     8'h59}, 1'b1, '{8'h59, FMT_24H, 1'b0}},
		'{'{CMD_INC,    IDX_SEC,     8'h00}, 1'b1, '{8'h00, FMT_24H, 1'b0}},
		'{'{CMD_DEC,    IDX_SEC,     8'h00}, 1'b1, '{8'h59, FMT_24H, 1'b0}},
		'{'{CMD_SPARE6, IDX_SEC,     8'hAA}, 1'b0, NO_RSP},
		'{'{CMD_WRITE,  IDX_MIN,     8'hFF}, 1'b1, '{8'hFF, FMT_24H, 1'b0}},
		'{'{CMD_INC,    IDX_MIN,     8'h00}, 1'b1, '{8'h00, FMT_24H, 1'b0}},
		'{'{CMD_WRITE,  IDX_HOUR,    8'h23}, 1'b1, '{8'h23, FMT_24H, 1'b0}},
		'{'{CMD_INC,    IDX_HOUR,    8'h00}, 1'b1, '{8'h00, FMT_24H, 1'b0}},
		'{'{CMD_DEC,    IDX_HOUR,    8'h00}, 1'b1, '{8'h23, FMT_24H, 1'b0}},
		'{'{CMD_MODE,   IDX_NONE,    8'h00}, 1'b0, NO_RSP},
		'{'{CMD_INC,    IDX_HOUR,    8'h00}, 1'b0, NO_RSP},
		'{'{CMD_INC,    IDX_HOUR,    8'h00}, 1'b0, NO_RSP},
		'{'{CMD_AMPM,   IDX_SEC,     8'h00}, 1'b0, NO_RSP},
		'{'{CMD_WRITE,  IDX_HOUR,    8'h52}, 1'b1, '{8'h52, FMT_AM, 1'b0}},
		'{'{CMD_MODE,   IDX_HOUR,    8'h00}, 1'b0, NO_RSP},
		'{'{CMD_WRITE,  IDX_HOUR,    8'h72}, 1'b1, '{8'h72, FMT_PM, 1'b0}},
		'{'{CMD_MODE,   IDX_HOUR,    8'h00}, 1'b0, NO_RSP},
		'{'{CMD_AMPM,   IDX_HOUR,    8'h00}, 1'b0, NO_RSP},
		'{'{CMD_WRITE,  IDX_WEEKDAY, 8'h07}, 1'b1, '{8'h07, FMT_24H, 1'b0}},
		'{'{CMD_INC,    IDX_WEEKDAY, 8'h00}, 1'b0, NO_RSP},
		'{'{CMD_WRITE,  IDX_DATE,    8'h01}, 1'b0, NO_RSP},
		'{'{CMD_DEC,    IDX_DATE,    8'h00}, 1'b0, NO_RSP},
		'{'{CMD_WRITE,  IDX_MONTH,   8'h92}, 1'b1, '{8'h92, FMT_24H, 1'b0}}
	};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// bench-side copy of the clock registers
	logic [7:0] clock_model [NumRegs];
	rsp_item_t  expected_rsps [$];
	rsp_item_t  want_rsp;

	int   send_idle_pct = 0;
	int   rsp_stall_pct = 0;
	logic hold_on       = 1'b0;
	event hold_off_ev;

	int errors       = 0;
	int num_sent     = 0;
	int num_rsp      = 0;
	int num_bad      = 0;
	int num_hold_bp  = 0;
	int cmd_count [8];

	bcd_clock_field_adjuster_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic int bcd_value(logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	function automatic logic [7:0] to_bcd(int v);
		int m;
		m = v % 100;
		return 8'(((m / 10) << 4) | (m % 10));
	endfunction

	// one step with wraparound; out-of-range snaps to lo going up, to hi going down
	function automatic int wrap_step(int v, int lo, int hi, logic up);
		if (up)
			return (v >= hi || v < lo) ? lo : v + 1;
		return (v <= lo || v > hi) ? hi : v - 1;
	endfunction

	function automatic logic [7:0] stepped_field(logic [2:0] idx, logic [7:0] cur, logic up);
		case (idx)
			IDX_SEC, IDX_MIN: return to_bcd(wrap_step(bcd_value(cur), 0, 59, up));
			IDX_WEEKDAY:      return to_bcd(wrap_step(bcd_value(cur), 1, 7, up));
			IDX_DATE:         return to_bcd(wrap_step(bcd_value(cur), 1, 31, up));
			IDX_MONTH:        return to_bcd(wrap_step(bcd_value(cur & MON_LOW), 1, 12, up));
			IDX_YEAR:         return to_bcd(wrap_step(bcd_value(cur), 0, 99, up));
			default: begin
				// hours: 24-hour uses the whole byte, 12-hour keeps the mode bits
				if (!cur[6])
					return to_bcd(wrap_step(bcd_value(cur), 0, 23, up));
				return to_bcd(wrap_step(bcd_value(cur & HR_LOW5), 1, 12, up))
					| HR_12H | (cur & HR_PM);
			end
		endcase
	endfunction

	function automatic logic [7:0] converted_hours(logic [7:0] h);
		int v;
		if (!h[6]) begin
			v = bcd_value(h);
			if (v > 23) v = 0;
			if (v == 0)       return to_bcd(12) | HR_12H;
			else if (v == 12) return to_bcd(12) | HR_12H | HR_PM;
			else if (v > 12)  return to_bcd(v - 12) | HR_12H | HR_PM;
			return to_bcd(v) | HR_12H;
		end
		v = bcd_value(h & HR_LOW5);
		if (v < 1 || v > 12) v = 12;
		if (!h[5])
			v = (v == 12) ? 0 : v;
		else
			v = (v == 12) ? 12 : v + 12;
		return to_bcd(v);
	endfunction

	// applies one command to the model and returns the response it gives
	function automatic rsp_item_t apply_command(req_item_t r);
		rsp_item_t  res;
		logic [7:0] h;
		res = '0;
		if (r.cmd == CMD_AMPM || r.cmd == CMD_MODE) begin
			h = clock_model[IDX_HOUR];
			if (r.cmd == CMD_MODE)
				h = converted_hours(h);
			else if (h[6] && h[5])
				h = h & ~HR_PM;
			else if (h[6])
				h = h | HR_PM;
			clock_model[IDX_HOUR] = h;
			res.field_value = h;
		end else if (r.field_index == IDX_NONE) begin
			res.bad_index = 1'b1;
		end else begin
			case (r.cmd)
				CMD_WRITE: clock_model[r.field_index] = r.write_data;
				CMD_INC:   clock_model[r.field_index] =
					stepped_field(r.field_index, clock_model[r.field_index], 1'b1);
				CMD_DEC:   clock_model[r.field_index] =
					stepped_field(r.field_index, clock_model[r.field_index], 1'b0);
				default: ;
			endcase
			res.field_value = clock_model[r.field_index];
		end
		h = clock_model[IDX_HOUR];
		if (!h[6])
			res.hour_format = FMT_24H;
		else
			res.hour_format = h[5] ? FMT_PM : FMT_AM;
		return res;
	endfunction

	// ---------------- stimulus ----------------

	// in-range value for a field, in the form a real clock would hold
	function automatic logic [7:0] legal_field_value(logic [2:0] idx);
		case (idx)
			IDX_SEC, IDX_MIN: return to_bcd($urandom_range(59));
			IDX_HOUR: begin
				if ($urandom_range(1))
					return to_bcd($urandom_range(23));
				return HR_12H | ($urandom_range(1) ? HR_PM : 8'h00)
					| to_bcd($urandom_range(12, 1));
			end
			IDX_WEEKDAY: return to_bcd($urandom_range(7, 1));
			IDX_DATE:    return to_bcd($urandom_range(31, 1));
			IDX_MONTH:   return ($urandom_range(1) ? CENTURY : 8'h00)
				| to_bcd($urandom_range(12, 1));
			IDX_YEAR:    return to_bcd($urandom_range(99));
			default:     return 8'($urandom);
		endcase
	endfunction

	function automatic req_item_t random_request();
		req_item_t r;
		int        pick;
		pick = $urandom_range(99);
		if (pick < 22)      r.cmd = CMD_WRITE;
		else if (pick < 32) r.cmd = CMD_READ;
		else if (pick < 54) r.cmd = CMD_INC;
		else if (pick < 76) r.cmd = CMD_DEC;
		else if (pick < 85) r.cmd = CMD_AMPM;
		else if (pick < 95) r.cmd = CMD_MODE;
		else if (pick < 97) r.cmd = CMD_SPARE6;
		else                r.cmd = CMD_SPARE7;
		// hours get extra weight; the unused index shows up now and then
		if ($urandom_range(15) == 0)
			r.field_index = IDX_NONE;
		else if ($urandom_range(3) == 0)
			r.field_index = IDX_HOUR;
		else
			r.field_index = 3'($urandom_range(NumRegs - 1));
		r.write_data = ($urandom_range(3) == 0) ? 8'($urandom) : legal_field_value(r.field_index);
		return r;
	endfunction

	// offers one item, records its expectation on acceptance, then maybe idles
	task automatic send_request(req_item_t it, logic has_want, rsp_item_t want);
		rsp_item_t res;
		req_valid <= 1'b1;
		req       <= it;
		do begin
			@(posedge clk);
			if (hold_on && req_stall) num_hold_bp++;
		end while (req_stall);
		res = apply_command(it);
		expected_rsps.push_back(has_want ? want : res);
		num_sent++;
		cmd_count[it.cmd]++;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			req       <= random_request();
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	initial begin : stimulus
		int i;
		int ph;
		for (i = 0; i < 8; i++) cmd_count[i] = 0;
		for (i = 0; i < NumRegs; i++) clock_model[i] = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_DIRECTED; i++)
			send_request(DIRECTED[i].stim, DIRECTED[i].has_want, DIRECTED[i].want);

		// phases: clean, sender gaps, receiver stalls, both light, long hold-off
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1:       begin send_idle_pct = 52; rsp_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  rsp_stall_pct = 52; end
				3:       begin send_idle_pct = 9;  rsp_stall_pct = 9;  end
				default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
			endcase
			if (ph == NUM_PHASES - 1) -> hold_off_ev;
			for (i = 0; i < ITEMS_PER_PHASE; i++)
				send_request(random_request(), 1'b0, NO_RSP);
		end
		req_valid <= 1'b0;

		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands (%0d directed), %0d responses, %0d bad-index results.",
			num_sent, NUM_DIRECTED, num_rsp, num_bad);
		$display("Commands wr %0d rd %0d inc %0d dec %0d ampm %0d mode %0d spare %0d;",
			cmd_count[CMD_WRITE], cmd_count[CMD_READ], cmd_count[CMD_INC], cmd_count[CMD_DEC],
			cmd_count[CMD_AMPM], cmd_count[CMD_MODE],
			cmd_count[CMD_SPARE6] + cmd_count[CMD_SPARE7]);
		$display("%0d cycles backed up.", num_hold_bp);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end

	// ---------------- receiver ----------------

	// long hold-off; the sender counts the backed-up cycles while it keeps pushing
	initial begin : long_hold
		forever begin
			@(hold_off_ev);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= hold_on || ($urandom_range(99) < rsp_stall_pct);
	end

	// compare each accepted response with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			num_rsp++;
			if (rsp.bad_index) num_bad++;
			if (expected_rsps.size() == 0) begin
				errors++;
				$display("%0t: unexpected response, got %p", $time, rsp);
			end else begin
				want_rsp = expected_rsps.pop_front();
				if (rsp.field_value !== want_rsp.field_value) begin
					errors++;
					$display("%0t: field_value expected %02h, got %02h",
						$time, want_rsp.field_value, rsp.field_value);
				end
				if (rsp.hour_format !== want_rsp.hour_format) begin
					errors++;
					$display("%0t: hour_format expected %0d, got %0d",
						$time, want_rsp.hour_format, rsp.hour_format);
				end
				if (rsp.bad_index !== want_rsp.bad_index) begin
					errors++;
					$display("%0t: bad_index expected %0b, got %0b",
						$time, want_rsp.bad_index, rsp.bad_index);
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timeout with %0d responses outstanding", expected_rsps.size());
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
src/bcfa_pkg.sv
src/bcfa_exec.sv
src/bcd_clock_field_adjuster_top.sv
src/bcfa_checker.sv
sim/bcd_clock_field_adjuster_top_tb.sv
